// File: rtl/jtm_pkg.sv
// Package for the joystick twist mapper: sizes, register indexes, codes,
// configuration and result structs, and the axis and button helpers.
// No dependencies.
`default_nettype none

package jtm_pkg;

    localparam int NUM_AXES    = 8;
    localparam int NUM_BUTTONS = 16;

    localparam int AXIS_PORTS = 8;
    localparam int BTN_W      = 16;
    localparam int AXIS_W     = 16;
    localparam int VAL_W      = 17;
    localparam int VEL_W      = 24;
    localparam int CFG_DATA_W = 18;
    localparam int CFG_IDX_W  = 3;

    localparam logic signed [VAL_W-1:0] BTN_POS = 17'sd32767;
    localparam logic signed [VAL_W-1:0] BTN_NEG = -17'sd32767;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE       = 3'd0,
        CFG_COMMAND_MODE = 3'd1,
        CFG_DEADZONE     = 3'd2,
        CFG_LINEAR_GAIN  = 3'd3,
        CFG_ANGULAR_GAIN = 3'd4,
        CFG_AXIS_MAP     = 3'd5,
        CFG_BUTTON_MAP   = 3'd6
    } cfg_idx_t;

    typedef enum logic [1:0] {
        KIND_TWIST  = 2'd0,
        KIND_FINISH = 2'd1,
        KIND_ABORT  = 2'd2
    } kind_t;

    localparam logic [1:0] MODE_TWIST = 2'd0;

    typedef logic signed [AXIS_W-1:0] axis_t;
    typedef axis_t [AXIS_PORTS-1:0]   axis_arr_t;
    typedef logic signed [VEL_W-1:0]  vel_t;

    typedef struct packed {
        logic        enable;
        logic [1:0]  command_mode;
        logic [15:0] deadzone;
        logic [15:0] linear_gain;
        logic [15:0] angular_gain;
        logic [17:0] axis_map;
        logic [15:0] button_map;
    } cfg_t;

    typedef struct packed {
        logic fin_seen;
        logic abt_seen;
    } flags_t;

    typedef struct packed {
        logic  emit;
        kind_t kind;
        vel_t  lin_x;
        vel_t  lin_y;
        vel_t  lin_z;
        vel_t  ang_x;
        vel_t  ang_y;
        vel_t  ang_z;
    } result_t;

    function automatic logic signed [VAL_W-1:0] axis_pick(axis_arr_t axes, logic [2:0] sel);
        logic signed [VAL_W-1:0] v;
        v = VAL_W'(axes[sel]);
        if (int'(sel) >= NUM_AXES)
            v = '0;
        return v;
    endfunction

    function automatic logic button_pick(logic [BTN_W-1:0] bits, logic [3:0] sel);
        logic b;
        b = bits[sel];
        if (int'(sel) >= NUM_BUTTONS)
            b = 1'b0;
        return b;
    endfunction

    function automatic logic signed [VAL_W-1:0] dead_zone(logic signed [VAL_W-1:0] v,
                                                          logic [15:0] dz);
        logic [VAL_W-1:0] mag;
        mag = v[VAL_W-1] ? VAL_W'(-v) : VAL_W'(v);
        return (mag < {1'b0, dz}) ? '0 : v;
    endfunction

    // negative half of a trigger folds onto 0..16383
    function automatic logic signed [VAL_W-1:0] trigger_val(logic signed [VAL_W-1:0] r,
                                                            logic [15:0] dz);
        logic signed [VAL_W-1:0] t;
        t = r[VAL_W-1] ? $signed({3'b000, r[14:1]}) : r;
        return dead_zone(t, dz);
    endfunction

endpackage

`default_nettype wire

// File: rtl/jtm_scale.sv
// One velocity component: signed value times unsigned Q8.8 gain, floored >> 8.
// Depends on jtm_pkg.
`default_nettype none

module jtm_scale
    import jtm_pkg::*;
(
    input  wire logic signed [VAL_W-1:0] value,
    input  wire logic [15:0]             gain,
    output vel_t                         vel
);

    logic signed [2*VAL_W-1:0] prod;

    assign prod = value * $signed({1'b0, gain});
    assign vel  = prod[VEL_W+7:8];

endmodule

`default_nettype wire

// File: rtl/jtm_compute.sv
// Per-sample decision and velocity datapath: button edges, axis selection,
// deadzone, triggers and six gain multipliers. Depends on jtm_pkg, jtm_scale.
`default_nettype none

module jtm_compute
    import jtm_pkg::*;
(
    input  wire cfg_t              cfg,
    input  wire flags_t            flags,
    input  wire axis_arr_t         axes,
    input  wire logic [BTN_W-1:0]  buttons,
    output flags_t                 flags_next,
    output result_t                res
);

    logic fin, abt, zp, zn;
    kind_t kind;
    logic signed [VAL_W-1:0] v_lx, v_ly, v_lz, v_ax, v_ay, v_az;
    vel_t s_lx, s_ly, s_lz, s_ax, s_ay, s_az;

    assign fin = button_pick(buttons, cfg.button_map[11:8]);
    assign abt = button_pick(buttons, cfg.button_map[15:12]);
    assign zp  = button_pick(buttons, cfg.button_map[3:0]);
    assign zn  = button_pick(buttons, cfg.button_map[7:4]);

    assign flags_next.fin_seen = fin;
    assign flags_next.abt_seen = abt;

    always_comb
    begin
        if (fin && !flags.fin_seen)
            kind = KIND_FINISH;
        else if (abt && !flags.abt_seen)
            kind = KIND_ABORT;
        else
            kind = KIND_TWIST;
    end

    assign v_lx = dead_zone(axis_pick(axes, cfg.axis_map[2:0]), cfg.deadzone);
    assign v_ly = dead_zone(axis_pick(axes, cfg.axis_map[5:3]), cfg.deadzone);
    assign v_lz = trigger_val(axis_pick(axes, cfg.axis_map[8:6]), cfg.deadzone)
                - trigger_val(axis_pick(axes, cfg.axis_map[11:9]), cfg.deadzone);
    assign v_ax = dead_zone(axis_pick(axes, cfg.axis_map[14:12]), cfg.deadzone);
    assign v_ay = dead_zone(axis_pick(axes, cfg.axis_map[17:15]), cfg.deadzone);
    assign v_az = (zp == zn) ? '0 : (zp ? BTN_POS : BTN_NEG);

    jtm_scale u_lx (.value(v_lx), .gain(cfg.linear_gain),  .vel(s_lx));
    jtm_scale u_ly (.value(v_ly), .gain(cfg.linear_gain),  .vel(s_ly));
    jtm_scale u_lz (.value(v_lz), .gain(cfg.linear_gain),  .vel(s_lz));
    jtm_scale u_ax (.value(v_ax), .gain(cfg.angular_gain), .vel(s_ax));
    jtm_scale u_ay (.value(v_ay), .gain(cfg.angular_gain), .vel(s_ay));
    jtm_scale u_az (.value(v_az), .gain(cfg.angular_gain), .vel(s_az));

    always_comb
    begin
        res.emit  = cfg.enable && (kind != KIND_TWIST || cfg.command_mode == MODE_TWIST);
        res.kind  = kind;
        res.lin_x = (kind == KIND_TWIST) ? s_lx : '0;
        res.lin_y = (kind == KIND_TWIST) ? s_ly : '0;
        res.lin_z = (kind == KIND_TWIST) ? s_lz : '0;
        res.ang_x = (kind == KIND_TWIST) ? s_ax : '0;
        res.ang_y = (kind == KIND_TWIST) ? s_ay : '0;
        res.ang_z = (kind == KIND_TWIST) ? s_az : '0;
    end

endmodule

`default_nettype wire

// File: rtl/joystick_twist_mapper.sv
// Joystick twist mapper: a sample beat yields a twist or a finish or abort request.
// A beat passes the input register, the datapath and the result register in that order;
// one beat per cycle is sustained while out_ready keeps the result register free.
// The six gain multipliers all sit in the single datapath stage between the two registers.
// Reset clears the pipeline valids and edge flags, and loads register defaults.
// Depends on jtm_pkg and jtm_compute.
`default_nettype none

module joystick_twist_mapper
    import jtm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,

    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire axis_t                 axis_0,
    input  wire axis_t                 axis_1,
    input  wire axis_t                 axis_2,
    input  wire axis_t                 axis_3,
    input  wire axis_t                 axis_4,
    input  wire axis_t                 axis_5,
    input  wire axis_t                 axis_6,
    input  wire axis_t                 axis_7,
    input  wire logic [BTN_W-1:0]      button_bits,

    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [1:0]                 kind,
    output vel_t                       lin_x,
    output vel_t                       lin_y,
    output vel_t                       lin_z,
    output vel_t                       ang_x,
    output vel_t                       ang_y,
    output vel_t                       ang_z
);

    cfg_t             cfg_reg;
    flags_t           flags_reg;
    flags_t           flags_next;
    logic             s1_valid_reg;
    axis_arr_t        axes_reg;
    logic [BTN_W-1:0] buttons_reg;
    logic             out_valid_reg;
    result_t          res_reg;
    result_t          res_next;
    logic             s2_free;
    logic             s1_fire;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable       <= 1'b0;
            cfg_reg.command_mode <= MODE_TWIST;
            cfg_reg.deadzone     <= 16'd3277;
            cfg_reg.linear_gain  <= 16'd256;
            cfg_reg.angular_gain <= 16'd256;
            cfg_reg.axis_map     <= 18'd146056;
            cfg_reg.button_map   <= 16'd4180;
        end
        else if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_ENABLE:       cfg_reg.enable       <= cfg_data[0];
                CFG_COMMAND_MODE: cfg_reg.command_mode <= cfg_data[1:0];
                CFG_DEADZONE:     cfg_reg.deadzone     <= cfg_data[15:0];
                CFG_LINEAR_GAIN:  cfg_reg.linear_gain  <= cfg_data[15:0];
                CFG_ANGULAR_GAIN: cfg_reg.angular_gain <= cfg_data[15:0];
                CFG_AXIS_MAP:     cfg_reg.axis_map     <= cfg_data;
                CFG_BUTTON_MAP:   cfg_reg.button_map   <= cfg_data[15:0];
                default:          ;
            endcase
        end
    end

    assign s2_free  = !out_valid_reg || out_ready;
    assign s1_fire  = s1_valid_reg && s2_free;
    assign in_ready = !s1_valid_reg || s2_free;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            axes_reg    <= {axis_7, axis_6, axis_5, axis_4, axis_3, axis_2, axis_1, axis_0};
            buttons_reg <= button_bits;
        end
    end

    jtm_compute u_compute (
        .cfg        (cfg_reg),
        .flags      (flags_reg),
        .axes       (axes_reg),
        .buttons    (buttons_reg),
        .flags_next (flags_next),
        .res        (res_next)
    );

    // edge flags move only on enabled beats
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            flags_reg <= '0;
        else if (s1_fire && cfg_reg.enable)
            flags_reg <= flags_next;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s2_free)
            out_valid_reg <= s1_fire && res_next.emit;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && res_next.emit)
            res_reg <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign kind      = res_reg.kind;
    assign lin_x     = res_reg.lin_x;
    assign lin_y     = res_reg.lin_y;
    assign lin_z     = res_reg.lin_z;
    assign ang_x     = res_reg.ang_x;
    assign ang_y     = res_reg.ang_y;
    assign ang_z     = res_reg.ang_z;

    a_disabled_flags_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && !cfg_reg.enable |=> flags_reg == $past(flags_reg))
        else $error("edge flags moved on a disabled beat");

    a_request_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.kind != KIND_TWIST |->
            res_reg.lin_x == '0 && res_reg.lin_y == '0 && res_reg.lin_z == '0 &&
            res_reg.ang_x == '0 && res_reg.ang_y == '0 && res_reg.ang_z == '0)
        else $error("request carries non-zero velocity");

    a_finish_edge: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && res_next.emit && res_next.kind == KIND_FINISH |-> !flags_reg.fin_seen)
        else $error("finish request without a rising edge");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> in_ready)
        else $error("input stalled with empty input register");

    a_drop_frees: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && !res_next.emit && !(in_valid && in_ready) |=> !s1_valid_reg)
        else $error("dropped beat left input register full");

endmodule

`default_nettype wire

// File: sim/joystick_twist_mapper_tb.sv
`timescale 1ns / 1ps
// Testbench for joystick_twist_mapper: a directed table, then randomised phases, with
// every result beat checked against a table value or the behavioural predictor held in this file.
// Depends on jtm_pkg and the joystick_twist_mapper RTL.

module joystick_twist_mapper_tb;
    import jtm_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SQUEEZE_CYCLES = 300;
    localparam int SQUEEZE_AFTER  = 800;
    localparam int PHASES         = 16;
    localparam int PHASE_ITEMS    = 105;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    localparam cfg_t CFG_AT_RESET = '{
        enable:       1'b0,
        command_mode: MODE_TWIST,
        deadzone:     16'd3277,
        linear_gain:  16'd256,
        angular_gain: 16'd256,
        axis_map:     18'd146056,
        button_map:   16'd4180
    };

    typedef enum logic [1:0] {ROW_CFG, ROW_SAMPLE} row_op_t;
    typedef enum logic [1:0] {EXP_PREDICT, EXP_NONE, EXP_GIVEN} row_exp_t;

    typedef struct packed {
        row_op_t               op;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        axis_arr_t             ax;
        logic [BTN_W-1:0]      btn;
        row_exp_t              chk;
        result_t               res;
    } row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    axis_arr_t             ax_drv;
    logic [BTN_W-1:0]      button_bits;
    logic                  out_valid;
    logic                  out_ready;
    logic [1:0]            kind;
    vel_t                  lin_x;
    vel_t                  lin_y;
    vel_t                  lin_z;
    vel_t                  ang_x;
    vel_t                  ang_y;
    vel_t                  ang_z;

    cfg_t    mirror;
    flags_t  edge_seen;
    result_t twist_q[$];
    result_t twist_head;
    row_t    dir_tab[$];
    int      errors;
    int      n_fed;
    int      quiet_cycles;
    bit      tx_calm;

    always #5 clk = ~clk;

    joystick_twist_mapper i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .axis_0     (ax_drv[0]),
        .axis_1     (ax_drv[1]),
        .axis_2     (ax_drv[2]),
        .axis_3     (ax_drv[3]),
        .axis_4     (ax_drv[4]),
        .axis_5     (ax_drv[5]),
        .axis_6     (ax_drv[6]),
        .axis_7     (ax_drv[7]),
        .button_bits(button_bits),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kind       (kind),
        .lin_x      (lin_x),
        .lin_y      (lin_y),
        .lin_z      (lin_z),
        .ang_x      (ang_x),
        .ang_y      (ang_y),
        .ang_z      (ang_z)
    );

    function automatic int tap(axis_arr_t ax, logic [2:0] sel);
        if (int'(sel) >= NUM_AXES)
            return 0;
        return int'(ax[sel]);
    endfunction

    function automatic bit pressed(logic [BTN_W-1:0] btn, logic [3:0] sel);
        if (int'(sel) >= NUM_BUTTONS)
            return 1'b0;
        return btn[sel];
    endfunction

    function automatic int clip(int v);
        int mag;
        mag = (v < 0) ? -v : v;
        return (mag < int'(mirror.deadzone)) ? 0 : v;
    endfunction

    // negative trigger travel folds onto the lower half
    function automatic int fold(int v);
        if (v < 0)
            v = (v + 32768) >>> 1;
        return clip(v);
    endfunction

    function automatic vel_t gained(int v, logic [15:0] g);
        longint prod;
        prod = longint'(v) * longint'(g);
        return vel_t'(prod >>> 8);
    endfunction

    function automatic result_t predict_twist(axis_arr_t ax, logic [BTN_W-1:0] btn);
        result_t r;
        logic    fin;
        logic    abt;
        logic    zp;
        logic    zn;
        int      zv;
        r = '0;
        if (!mirror.enable)
            return r;
        fin = pressed(btn, mirror.button_map[11:8]);
        abt = pressed(btn, mirror.button_map[15:12]);
        if (fin && !edge_seen.fin_seen)
        begin
            r.emit = 1'b1;
            r.kind = KIND_FINISH;
        end
        else if (abt && !edge_seen.abt_seen)
        begin
            r.emit = 1'b1;
            r.kind = KIND_ABORT;
        end
        edge_seen.fin_seen = fin;
        edge_seen.abt_seen = abt;
        if (r.emit || mirror.command_mode != MODE_TWIST)
            return r;
        zp = pressed(btn, mirror.button_map[3:0]);
        zn = pressed(btn, mirror.button_map[7:4]);
        zv = (zp == zn) ? 0 : (zp ? 32767 : -32767);
        r.emit  = 1'b1;
        r.kind  = KIND_TWIST;
        r.lin_x = gained(clip(tap(ax, mirror.axis_map[2:0])), mirror.linear_gain);
        r.lin_y = gained(clip(tap(ax, mirror.axis_map[5:3])), mirror.linear_gain);
        r.lin_z = gained(fold(tap(ax, mirror.axis_map[8:6])) -
                         fold(tap(ax, mirror.axis_map[11:9])), mirror.linear_gain);
        r.ang_x = gained(clip(tap(ax, mirror.axis_map[14:12])), mirror.angular_gain);
        r.ang_y = gained(clip(tap(ax, mirror.axis_map[17:15])), mirror.angular_gain);
        r.ang_z = gained(zv, mirror.angular_gain);
        return r;
    endfunction

    function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        case (idx)
            CFG_ENABLE:       mirror.enable       = d[0];
            CFG_COMMAND_MODE: mirror.command_mode = d[1:0];
            CFG_DEADZONE:     mirror.deadzone     = d[15:0];
            CFG_LINEAR_GAIN:  mirror.linear_gain  = d[15:0];
            CFG_ANGULAR_GAIN: mirror.angular_gain = d[15:0];
            CFG_AXIS_MAP:     mirror.axis_map     = d[17:0];
            CFG_BUTTON_MAP:   mirror.button_map   = d[15:0];
            default: ;
        endcase
    endfunction

    function automatic row_t put(logic [CFG_IDX_W-1:0] idx, int data);
        row_t r;
        r      = '0;
        r.op   = ROW_CFG;
        r.idx  = idx;
        r.data = CFG_DATA_W'(data);
        return r;
    endfunction

    function automatic row_t hit(int a0, int a1, int a2, int a3, int a4, int a5, int a6,
                                 int a7, int btn);
        row_t r;
        r       = '0;
        r.op    = ROW_SAMPLE;
        r.chk   = EXP_PREDICT;
        r.ax[0] = axis_t'(a0);
        r.ax[1] = axis_t'(a1);
        r.ax[2] = axis_t'(a2);
        r.ax[3] = axis_t'(a3);
        r.ax[4] = axis_t'(a4);
        r.ax[5] = axis_t'(a5);
        r.ax[6] = axis_t'(a6);
        r.ax[7] = axis_t'(a7);
        r.btn   = BTN_W'(btn);
        return r;
    endfunction

    function automatic row_t want(row_t r, kind_t k, int lx = 0, int ly = 0, int lz = 0,
                                  int wx = 0, int wy = 0, int wz = 0);
        r.chk       = EXP_GIVEN;
        r.res       = '0;
        r.res.emit  = 1'b1;
        r.res.kind  = k;
        r.res.lin_x = vel_t'(lx);
        r.res.lin_y = vel_t'(ly);
        r.res.lin_z = vel_t'(lz);
        r.res.ang_x = vel_t'(wx);
        r.res.ang_y = vel_t'(wy);
        r.res.ang_z = vel_t'(wz);
        return r;
    endfunction

    function automatic row_t quiet(row_t r);
        r.chk = EXP_NONE;
        return r;
    endfunction

    function automatic int idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 45);
    endfunction

    function automatic axis_t rand_axis();
        int d;
        d = int'(mirror.deadzone) + $urandom_range(0, 2) - 1;
        case ($urandom_range(0, 5))
            0:       return axis_t'(-32768);
            1:       return axis_t'(32767);
            2:       return $urandom_range(0, 1) ? axis_t'(0) : axis_t'(-1);
            3:       return $urandom_range(0, 1) ? axis_t'(d) : axis_t'(-d);
            default: return axis_t'($urandom);
        endcase
    endfunction

    function automatic logic [BTN_W-1:0] rand_buttons(logic [BTN_W-1:0] prev);
        case ($urandom_range(0, 9))
            0:       return '0;
            1, 2, 3: return BTN_W'($urandom);
            default: return prev ^ (BTN_W'(1) << $urandom_range(0, BTN_W - 1));
        endcase
    endfunction

    task automatic check_field(string name, int exp_val, int got_val);
        if (exp_val != got_val)
        begin
            $error("%s: expected %0d, got %0d", name, exp_val, got_val);
            errors++;
        end
    endtask

    // called at a falling edge; cfg_valid is left high for the caller to drop
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_cfg(idx, d);
        @(negedge clk);
    endtask

    task automatic quiesce(int tail);
        in_valid = 1'b0;
        while (twist_q.size() != 0)
            @(negedge clk);
        repeat (tail) @(negedge clk);
    endtask

    // called at a falling edge; in_valid stays high unless a gap follows
    task automatic feed(axis_arr_t ax, logic [BTN_W-1:0] btn, row_exp_t chk, result_t given);
        result_t r;
        int      gap;
        in_valid    = 1'b1;
        ax_drv      = ax;
        button_bits = btn;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        r = predict_twist(ax, btn);
        n_fed++;
        if (chk == EXP_GIVEN)
            twist_q.push_back(given);
        else if (chk == EXP_PREDICT && r.emit)
            twist_q.push_back(r);
        @(negedge clk);
        gap = tx_calm ? 0 : idle_len();
        if (gap != 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic shuffle_config(int phase);
        logic [CFG_DATA_W-1:0] d;
        for (int i = CFG_ENABLE; i <= CFG_BUTTON_MAP; i++)
        begin
            d = CFG_DATA_W'($urandom);
            case (i)
                CFG_ENABLE:
                    d[0] = ($urandom_range(0, 7) != 0);
                CFG_COMMAND_MODE:
                    if ($urandom_range(0, 2) != 0)
                        d[1:0] = MODE_TWIST;
                CFG_DEADZONE:
                    case ($urandom_range(0, 5))
                        0: d[15:0] = 16'h0000;
                        1: d[15:0] = 16'h8000;
                        2: d[15:0] = 16'hFFFF;
                        3: d[15:0] = 16'($urandom_range(0, 4000));
                        default: ;
                    endcase
                CFG_LINEAR_GAIN, CFG_ANGULAR_GAIN:
                    case ($urandom_range(0, 4))
                        0: d[15:0] = 16'h0000;
                        1: d[15:0] = 16'h0100;
                        2: d[15:0] = 16'hFFFF;
                        default: ;
                    endcase
                default: ;
            endcase
            if (phase == 0 || $urandom_range(0, 1) != 0)
                write_reg(CFG_IDX_W'(i), d);
        end
        if ($urandom_range(0, 7) == 0)
            write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
        cfg_valid = 1'b0;
    endtask

    initial
    begin
        axis_arr_t        ax;
        logic [BTN_W-1:0] btn;
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        ax_drv      = '0;
        button_bits = '0;
        mirror      = CFG_AT_RESET;
        edge_seen   = '0;
        errors      = 0;
        n_fed       = 0;
        tx_calm     = 1'b0;

        // disabled after reset: finish press is ignored and leaves the edge flags alone
        dir_tab.push_back(quiet(hit(0, 0, 0, 0, 0, 0, 0, 0, 'h0001)));
        dir_tab.push_back(put(CFG_ENABLE, 1));
        dir_tab.push_back(want(hit(0, 0, 0, 0, 0, 0, 0, 0, 'h0000), KIND_TWIST));
        dir_tab.push_back(want(hit(32767, -32768, 32767, 100, -3277, -32768, 0, 0, 'h0010),
                               KIND_TWIST, 32767, -32768, 32767, 0, -3277, 32767));
        dir_tab.push_back(want(hit(0, 0, 0, 0, 0, 0, 0, 0, 'h0001), KIND_FINISH));
        dir_tab.push_back(want(hit(0, 0, 0, 0, 0, 0, 0, 0, 'h0003), KIND_ABORT));
        dir_tab.push_back(want(hit(0, 0, 0, 0, 0, 0, 0, 0, 'h0003), KIND_TWIST));
        dir_tab.push_back(want(hit(0, 0, 0, 0, 0, 0, 0, 0, 'h0000), KIND_TWIST));
        // both edges at once: finish wins
        dir_tab.push_back(want(hit(0, 0, 0, 0, 0, 0, 0, 0, 'h0003), KIND_FINISH));
        dir_tab.push_back(want(hit(0, 0, 0, 0, 0, 0, 0, 0, 'h0002), KIND_TWIST));
        dir_tab.push_back(want(hit(0, 0, 0, 0, 0, 0, 0, 0, 'h0001), KIND_FINISH));
        dir_tab.push_back(want(hit(0, 0, 0, 0, 0, 0, 0, 0, 'h0030), KIND_TWIST));
        dir_tab.push_back(want(hit(0, 0, 0, 0, 0, 0, 0, 0, 'h0020), KIND_TWIST,
                               0, 0, 0, 0, 0, -32767));
        dir_tab.push_back(hit(-1, 3276, -1, 3277, -32767, -2, -32768, 32767, 'h0000));
        dir_tab.push_back(put(CFG_LINEAR_GAIN, 'hFFFF));
        dir_tab.push_back(put(CFG_ANGULAR_GAIN, 'hFFFF));
        dir_tab.push_back(hit(-32768, 32767, -32768, 32767, -32768, 32767, 0, 0, 'h0020));
        dir_tab.push_back(put(CFG_DEADZONE, 0));
        dir_tab.push_back(hit(1, -1, -1, 0, -2, 2, 0, 0, 'h0010));
        dir_tab.push_back(put(CFG_DEADZONE, 'h8000));
        dir_tab.push_back(hit(-32768, 32767, -32768, 32767, 32767, -32768, 0, 0, 'h0010));
        dir_tab.push_back(put(CFG_LINEAR_GAIN, 0));
        dir_tab.push_back(hit(-32768, -32768, 32767, -32768, 0, 0, 0, 0, 'h0000));
        dir_tab.push_back(put(CFG_AXIS_MAP, 'h3FFFF));
        dir_tab.push_back(put(CFG_BUTTON_MAP, 'hFFFF));
        dir_tab.push_back(want(hit(0, 0, 0, 0, 0, 0, 0, -32768, 'h8000), KIND_FINISH));
        dir_tab.push_back(hit(0, 0, 0, 0, 0, 0, 0, -32768, 'h8000));
        dir_tab.push_back(put(CFG_COMMAND_MODE, 1));
        dir_tab.push_back(quiet(hit(0, 0, 0, 0, 0, 0, 0, 32767, 'h0000)));
        dir_tab.push_back(want(hit(0, 0, 0, 0, 0, 0, 0, 32767, 'h8000), KIND_FINISH));
        dir_tab.push_back(put(CFG_COMMAND_MODE, 2));
        dir_tab.push_back(quiet(hit(0, 0, 0, 0, 0, 0, 0, 32767, 'h8000)));
        dir_tab.push_back(put(CFG_COMMAND_MODE, 3));
        dir_tab.push_back(quiet(hit(0, 0, 0, 0, 0, 0, 0, 32767, 'h0000)));
        dir_tab.push_back(put(CFG_SPARE, 'h3FFFF));
        dir_tab.push_back(put(CFG_ENABLE, 0));
        dir_tab.push_back(quiet(hit(0, 0, 0, 0, 0, 0, 0, 32767, 'h8000)));
        dir_tab.push_back(put(CFG_ENABLE, 1));
        dir_tab.push_back(put(CFG_COMMAND_MODE, 0));
        dir_tab.push_back(want(hit(0, 0, 0, 0, 0, 0, 0, 0, 'h8000), KIND_FINISH));

        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].op == ROW_CFG)
            begin
                quiesce(SETTLE_CYCLES);
                write_reg(dir_tab[i].idx, dir_tab[i].data);
                cfg_valid = 1'b0;
            end
            else
                feed(dir_tab[i].ax, dir_tab[i].btn, dir_tab[i].chk, dir_tab[i].res);
        end

        btn = '0;
        for (int p = 0; p < PHASES; p++)
        begin
            quiesce(SETTLE_CYCLES);
            shuffle_config(p);
            tx_calm = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                for (int a = 0; a < AXIS_PORTS; a++)
                    ax[a] = rand_axis();
                btn = rand_buttons(btn);
                feed(ax, btn, EXP_PREDICT, '0);
            end
        end

        quiesce(TAIL_CYCLES);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // result side: random stalls, calm stretches, and one long hold-off
    initial
    begin
        int stall;
        int span;
        bit calm;
        bit squeezed;
        stall     = 0;
        span      = 0;
        calm      = 1'b0;
        squeezed  = 1'b0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!squeezed && n_fed >= SQUEEZE_AFTER && out_valid)
            begin
                squeezed  = 1'b1;
                out_ready = 1'b0;
                repeat (SQUEEZE_CYCLES) @(negedge clk);
            end
            if (span == 0)
            begin
                calm = ($urandom_range(0, 3) == 0);
                span = $urandom_range(50, 200);
            end
            span--;
            if (stall != 0)
            begin
                stall--;
                out_ready = 1'b0;
            end
            else
            begin
                out_ready = 1'b1;
                if (!calm)
                    stall = idle_len();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (twist_q.size() == 0)
            begin
                $error("result beat with nothing expected: kind %0d", kind);
                errors++;
            end
            else
            begin
                twist_head = twist_q.pop_front();
                check_field("kind", int'(twist_head.kind), int'(kind));
                check_field("lin_x", int'(twist_head.lin_x), int'(lin_x));
                check_field("lin_y", int'(twist_head.lin_y), int'(lin_y));
                check_field("lin_z", int'(twist_head.lin_z), int'(lin_z));
                check_field("ang_x", int'(twist_head.ang_x), int'(ang_x));
                check_field("ang_y", int'(twist_head.ang_y), int'(ang_y));
                check_field("ang_z", int'(twist_head.ang_z), int'(ang_z));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

endmodule
